// File: rtl/tlqs_pkg.sv
// Shared types and constants of the two-level queue scheduler.
// No dependencies; imported by every module of the block.
package tlqs_pkg;

  localparam int ArrW   = 16;
  localparam int BurstW = 16;
  localparam int JobW   = 8;
  localparam int ClkW   = 24;
  localparam int DiffW  = 25;
  localparam int SumW   = 32;

  // result status codes
  localparam logic [1:0] ST_LOADED  = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_EXEC    = 2'd2;
  localparam logic [1:0] ST_NONE    = 2'd3;

  // command queue between front and back
  localparam int CmdqDepth = 2;
  localparam int CmdqAw    = 1;

  typedef struct packed {
    logic              is_dispatch;
    logic              user;
    logic [ArrW-1:0]   arrival;
    logic [BurstW-1:0] burst;
  } cmd_t;

  typedef struct packed {
    logic [JobW-1:0]   number;
    logic [ArrW-1:0]   arrival;
    logic [BurstW-1:0] burst;
  } job_t;

endpackage

// File: rtl/tlqs_front.sv
// Front end: takes input transfers, decodes them into commands and holds
// them in a two-entry command queue. Depends on tlqs_pkg.
module tlqs_front
  import tlqs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic [ArrW-1:0]   in_arrival_time,
  input  logic [BurstW-1:0] in_burst_time,
  input  logic              in_user_class,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output cmd_t              cmd
);

  cmd_t              q_r [CmdqDepth];
  logic [CmdqAw-1:0] wr_ptr_r, rd_ptr_r;
  logic [CmdqAw:0]   cnt_r;
  logic              push, pop;
  cmd_t              dec;

  assign in_ready  = (cnt_r != (CmdqAw+1)'(CmdqDepth));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    dec.is_dispatch = in_mode;
    dec.user        = in_user_class;
    dec.arrival     = in_arrival_time;
    dec.burst       = in_burst_time;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/tlqs_back.sv
// Back end: the two job FIFOs, the scheduler clock, the running totals and
// the result register. Depends on tlqs_pkg.
module tlqs_back
  import tlqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cmd_valid,
  output logic                    cmd_ready,
  input  cmd_t                    cmd,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic [JobW-1:0]         out_job_number,
  output logic                    out_from_user_queue,
  output logic [ClkW-1:0]         out_completion_time,
  output logic signed [DiffW-1:0] out_turnaround,
  output logic signed [DiffW-1:0] out_waiting,
  output logic signed [SumW-1:0]  out_turnaround_total,
  output logic signed [SumW-1:0]  out_waiting_total
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PtrLast = PW'(QUEUE_DEPTH - 1);
  localparam logic [FW-1:0] FillMax = FW'(QUEUE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_TAT  = 2'd2;
  localparam logic [1:0] S_SUM  = 2'd3;

  job_t sys_mem [QUEUE_DEPTH];
  job_t usr_mem [QUEUE_DEPTH];
  job_t sys_rdata_r, usr_rdata_r, job;

  logic [1:0]        state_r;
  logic [PW-1:0]     sys_rd_r, sys_wr_r, usr_rd_r, usr_wr_r;
  logic [FW-1:0]     sys_fill_r, usr_fill_r;
  logic [ClkW-1:0]   clock_r;
  logic [SumW-1:0]   tsum_r, wsum_r;
  logic [JobW-1:0]   next_number_r, next_number_nxt;
  logic              sel_user_r;
  logic [ArrW-1:0]   arr_r;
  logic [ArrW:0]     ab_r;
  logic [JobW-1:0]   num_r;
  logic [DiffW-1:0]  tat_r, wt_r;
  logic [DiffW-1:0]  clk_sum;
  logic              out_valid_r;
  logic [1:0]        status_r;
  logic [JobW-1:0]   job_r;
  logic              user_r;
  logic [ClkW-1:0]   comp_r;
  logic [DiffW-1:0]  otat_r, owt_r;

  logic start, is_load, full, sys_wen, usr_wen, sys_has, usr_has;

  assign start     = (state_r == S_IDLE) && cmd_valid && !out_valid_r;
  assign cmd_ready = start;
  assign is_load   = !cmd.is_dispatch;
  assign full      = cmd.user ? (usr_fill_r == FillMax) : (sys_fill_r == FillMax);
  assign sys_wen   = start && is_load && !full && !cmd.user;
  assign usr_wen   = start && is_load && !full && cmd.user;
  assign sys_has   = (sys_fill_r != '0);
  assign usr_has   = (usr_fill_r != '0);

  assign next_number_nxt = (next_number_r == '1) ? JobW'(1) : next_number_r + 1'b1;
  assign job     = sel_user_r ? usr_rdata_r : sys_rdata_r;
  assign clk_sum = {1'b0, clock_r} + DiffW'(job.burst);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  // FIFO memories: read data tracks the head entry every cycle
  always_ff @(posedge clk) begin
    if (sys_wen) begin
      sys_mem[sys_wr_r] <= '{next_number_r, cmd.arrival, cmd.burst};
    end
    if (usr_wen) begin
      usr_mem[usr_wr_r] <= '{next_number_r, cmd.arrival, cmd.burst};
    end
    sys_rdata_r <= sys_mem[sys_rd_r];
    usr_rdata_r <= usr_mem[usr_rd_r];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start && cmd.is_dispatch) begin
      sel_user_r <= !sys_has;
    end
    if (state_r == S_EXEC) begin
      arr_r <= job.arrival;
      ab_r  <= (ArrW+1)'(job.arrival) + (ArrW+1)'(job.burst);
      num_r <= job.number;
    end
    if (state_r == S_TAT) begin
      tat_r <= {1'b0, clock_r} - DiffW'(arr_r);
      wt_r  <= {1'b0, clock_r} - DiffW'(ab_r);
    end
    if (start) begin
      job_r  <= '0;
      user_r <= 1'b0;
      comp_r <= '0;
      otat_r <= '0;
      owt_r  <= '0;
      if (is_load) begin
        status_r <= full ? ST_DROPPED : ST_LOADED;
        job_r    <= full ? '0 : next_number_r;
      end else if (!sys_has && !usr_has) begin
        status_r <= ST_NONE;
      end
    end else if (state_r == S_SUM) begin
      status_r <= ST_EXEC;
      job_r    <= num_r;
      user_r   <= sel_user_r;
      comp_r   <= clock_r;
      otat_r   <= tat_r;
      owt_r    <= wt_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      sys_rd_r      <= '0;
      sys_wr_r      <= '0;
      usr_rd_r      <= '0;
      usr_wr_r      <= '0;
      sys_fill_r    <= '0;
      usr_fill_r    <= '0;
      clock_r       <= '0;
      tsum_r        <= '0;
      wsum_r        <= '0;
      next_number_r <= JobW'(1);
      out_valid_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            if (is_load) begin
              out_valid_r <= 1'b1;
              if (sys_wen) begin
                sys_wr_r      <= ptr_inc(sys_wr_r);
                sys_fill_r    <= sys_fill_r + 1'b1;
                next_number_r <= next_number_nxt;
              end
              if (usr_wen) begin
                usr_wr_r      <= ptr_inc(usr_wr_r);
                usr_fill_r    <= usr_fill_r + 1'b1;
                next_number_r <= next_number_nxt;
              end
            end else if (sys_has) begin
              sys_rd_r   <= ptr_inc(sys_rd_r);
              sys_fill_r <= sys_fill_r - 1'b1;
              state_r    <= S_EXEC;
            end else if (usr_has) begin
              usr_rd_r   <= ptr_inc(usr_rd_r);
              usr_fill_r <= usr_fill_r - 1'b1;
              state_r    <= S_EXEC;
            end else begin
              out_valid_r <= 1'b1;
            end
          end
        end
        S_EXEC: begin
          // clock saturates at its top value
          clock_r <= clk_sum[DiffW-1] ? '1 : clk_sum[ClkW-1:0];
          state_r <= S_TAT;
        end
        S_TAT: begin
          state_r <= S_SUM;
        end
        S_SUM: begin
          tsum_r      <= tsum_r + {{(SumW-DiffW){tat_r[DiffW-1]}}, tat_r};
          wsum_r      <= wsum_r + {{(SumW-DiffW){wt_r[DiffW-1]}}, wt_r};
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_job_number       = job_r;
  assign out_from_user_queue  = user_r;
  assign out_completion_time  = comp_r;
  assign out_turnaround       = otat_r;
  assign out_waiting          = owt_r;
  assign out_turnaround_total = tsum_r;
  assign out_waiting_total    = wsum_r;

endmodule

// File: rtl/two_level_queue_scheduler_core.sv
// Two-level FCFS job scheduler, top level.
// Depends on tlqs_pkg, tlqs_front and tlqs_back.
//
// Loads put a job into the system or user FIFO (QUEUE_DEPTH entries each)
// and return its job number, or a drop flag when that FIFO is full.
// Dispatches run the oldest system job, else the oldest user job, and
// return completion, turnaround and waiting time plus running totals.
// A two-entry command queue decouples input transfers from execution.
// In the back end a dispatch steps through the FIFO memory read, the
// clock add with saturation, the two differences, then the totals; the
// result register must be emptied before the next command starts, so the
// back end takes no new command until the last result has been taken.
// Results come out in order, one per input transfer.
module two_level_queue_scheduler_core
  import tlqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_mode,
  input  logic [ArrW-1:0]         in_arrival_time,
  input  logic [BurstW-1:0]       in_burst_time,
  input  logic                    in_user_class,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic [JobW-1:0]         out_job_number,
  output logic                    out_from_user_queue,
  output logic [ClkW-1:0]         out_completion_time,
  output logic signed [DiffW-1:0] out_turnaround,
  output logic signed [DiffW-1:0] out_waiting,
  output logic signed [SumW-1:0]  out_turnaround_total,
  output logic signed [SumW-1:0]  out_waiting_total
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  tlqs_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_arrival_time (in_arrival_time),
    .in_burst_time   (in_burst_time),
    .in_user_class   (in_user_class),
    .cmd_valid       (cmd_valid),
    .cmd_ready       (cmd_ready),
    .cmd             (cmd)
  );

  tlqs_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd_valid            (cmd_valid),
    .cmd_ready            (cmd_ready),
    .cmd                  (cmd),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_job_number       (out_job_number),
    .out_from_user_queue  (out_from_user_queue),
    .out_completion_time  (out_completion_time),
    .out_turnaround       (out_turnaround),
    .out_waiting          (out_waiting),
    .out_turnaround_total (out_turnaround_total),
    .out_waiting_total    (out_waiting_total)
  );

endmodule

// File: rtl/tlqs_checker.sv
// Port-level checks of the scheduler results, bound to the top level.
// Depends on tlqs_pkg.
module tlqs_checker
  import tlqs_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [1:0]              out_status,
  input logic [JobW-1:0]         out_job_number,
  input logic                    out_from_user_queue,
  input logic [ClkW-1:0]         out_completion_time,
  input logic signed [DiffW-1:0] out_turnaround,
  input logic signed [DiffW-1:0] out_waiting
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_job_number) && $stable(out_turnaround))
    else $error("result changed while stalled");

  a_load_num: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_LOADED) |-> out_job_number != '0)
    else $error("loaded job got number zero");

  a_no_num: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == ST_DROPPED) || (out_status == ST_NONE))
      |-> out_job_number == '0)
    else $error("job number on drop or empty dispatch");

  a_zero_times: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_EXEC) |-> !out_from_user_queue
      && (out_completion_time == '0) && (out_turnaround == '0) && (out_waiting == '0))
    else $error("time fields set on a non-executed result");

  a_wait_le_tat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EXEC) |-> out_waiting <= out_turnaround)
    else $error("waiting exceeds turnaround");

endmodule

bind two_level_queue_scheduler_core tlqs_checker u_tlqs_checker (.*);

// File: test/tb_two_level_queue_scheduler_core.sv
// Testbench for two_level_queue_scheduler_core: directed and random job loads
// and dispatches, each result checked against an in-bench scheduler model.
// Depends on tlqs_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_two_level_queue_scheduler_core;
  import tlqs_pkg::*;

  localparam int QDEPTH = 64;

  localparam logic MODE_LOAD     = 1'b0;
  localparam logic MODE_DISPATCH = 1'b1;
  localparam logic CLASS_SYSTEM  = 1'b0;
  localparam logic CLASS_USER    = 1'b1;

  localparam logic [ClkW-1:0]   CLOCK_MAX = '1;
  localparam logic [BurstW-1:0] TICK_MAX  = '1;

  typedef struct packed {
    logic [1:0]       status;
    logic [JobW-1:0]  number;
    logic             from_user;
    logic [ClkW-1:0]  completion;
    logic [DiffW-1:0] turnaround;
    logic [DiffW-1:0] waiting;
    logic [SumW-1:0]  turnaround_total;
    logic [SumW-1:0]  waiting_total;
  } sched_result_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_mode = MODE_LOAD;
  logic [ArrW-1:0]   in_arrival_time = '0;
  logic [BurstW-1:0] in_burst_time = '0;
  logic              in_user_class = CLASS_SYSTEM;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_status;
  logic [JobW-1:0]   out_job_number;
  logic              out_from_user_queue;
  logic [ClkW-1:0]   out_completion_time;
  logic signed [DiffW-1:0] out_turnaround;
  logic signed [DiffW-1:0] out_waiting;
  logic signed [SumW-1:0]  out_turnaround_total;
  logic signed [SumW-1:0]  out_waiting_total;

  two_level_queue_scheduler_core #(.QUEUE_DEPTH(QDEPTH)) u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_mode              (in_mode),
    .in_arrival_time      (in_arrival_time),
    .in_burst_time        (in_burst_time),
    .in_user_class        (in_user_class),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_job_number       (out_job_number),
    .out_from_user_queue  (out_from_user_queue),
    .out_completion_time  (out_completion_time),
    .out_turnaround       (out_turnaround),
    .out_waiting          (out_waiting),
    .out_turnaround_total (out_turnaround_total),
    .out_waiting_total    (out_waiting_total)
  );

  // scheduler model state, indexed by class (0 system, 1 user)
  job_t            job_fifo [2][QDEPTH];
  int              fifo_rd [2] = '{0, 0};
  int              fifo_cnt [2] = '{0, 0};
  logic [ClkW-1:0] sched_clock = '0;
  logic [SumW-1:0] tat_acc = '0;
  logic [SumW-1:0] wt_acc = '0;
  logic [JobW-1:0] next_job = 8'd1;
  logic            tat_carry = 1'b0;

  sched_result_t expected_results[$];
  int            err_count = 0;
  logic          in_steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 40) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // advance the model by one accepted item and queue the result it gives
  task automatic schedule_item(input logic mode, input logic [ArrW-1:0] arr,
                               input logic [BurstW-1:0] burst, input logic cls);
    sched_result_t r;
    job_t          job;
    int            sel;
    logic [ClkW:0] clk_sum;
    logic [SumW-1:0] tat32;
    logic [SumW-1:0] wt32;
    logic [SumW-1:0] prev;
    r = '0;
    if (mode == MODE_LOAD) begin
      if (fifo_cnt[cls] >= QDEPTH) begin
        r.status = ST_DROPPED;
      end else begin
        job_fifo[cls][(fifo_rd[cls] + fifo_cnt[cls]) % QDEPTH] = '{next_job, arr, burst};
        fifo_cnt[cls]++;
        r.status = ST_LOADED;
        r.number = next_job;
        next_job = (next_job >= 8'd255) ? 8'd1 : next_job + 8'd1;
      end
    end else begin
      sel = -1;
      if (fifo_cnt[CLASS_SYSTEM] != 0) sel = CLASS_SYSTEM;
      else if (fifo_cnt[CLASS_USER] != 0) sel = CLASS_USER;
      if (sel < 0) begin
        r.status = ST_NONE;
      end else begin
        job = job_fifo[sel][fifo_rd[sel]];
        fifo_rd[sel] = (fifo_rd[sel] + 1) % QDEPTH;
        fifo_cnt[sel]--;
        clk_sum = {1'b0, sched_clock} + job.burst;
        sched_clock = clk_sum[ClkW] ? CLOCK_MAX : clk_sum[ClkW-1:0];
        tat32 = SumW'(sched_clock) - SumW'(job.arrival);
        wt32 = tat32 - SumW'(job.burst);
        prev = tat_acc;
        tat_acc = tat_acc + tat32;
        if (tat_acc < prev) tat_carry = 1'b1;
        wt_acc = wt_acc + wt32;
        r.status = ST_EXEC;
        r.number = job.number;
        r.from_user = (sel == CLASS_USER);
        r.completion = sched_clock;
        r.turnaround = tat32[DiffW-1:0];
        r.waiting = wt32[DiffW-1:0];
      end
    end
    r.turnaround_total = tat_acc;
    r.waiting_total = wt_acc;
    expected_results.push_back(r);
  endtask

  // mostly short gaps, a few long ones
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] rand_tick();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 16'($urandom_range(0, 15));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // called and returns at a rising edge; valid stays high if the next call has no gap
  task automatic send_item(input logic mode, input logic [ArrW-1:0] arr,
                           input logic [BurstW-1:0] burst, input logic cls);
    int gap;
    gap = in_steady ? 0 : idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_arrival_time <= arr;
    in_burst_time <= burst;
    in_user_class <= cls;
    do @(posedge clk); while (!in_ready);
    schedule_item(mode, arr, burst, cls);
  endtask

  task automatic send_dispatch();
    send_item(MODE_DISPATCH, rand_tick(), rand_tick(), 1'($urandom_range(0, 1)));
  endtask

  // empty dispatch, priority order, FCFS, field extremes, negative turnaround
  task automatic test_directed_cases();
    send_item(MODE_DISPATCH, '0, '0, CLASS_SYSTEM);
    send_item(MODE_LOAD, '0, '0, CLASS_USER);
    send_item(MODE_LOAD, TICK_MAX, 16'd1, CLASS_SYSTEM);
    send_item(MODE_LOAD, '0, TICK_MAX, CLASS_SYSTEM);
    send_item(MODE_LOAD, TICK_MAX, TICK_MAX, CLASS_USER);
    repeat (4) send_item(MODE_DISPATCH, TICK_MAX, TICK_MAX, CLASS_USER);
    send_item(MODE_DISPATCH, '0, '0, CLASS_USER);
    send_item(MODE_LOAD, '0, '0, CLASS_SYSTEM);
    send_item(MODE_DISPATCH, '0, '0, CLASS_SYSTEM);
  endtask

  // overfill each class so loads drop, then drain both and dispatch once more;
  // the longest bursts push the clock well toward saturation
  task automatic test_queue_full();
    for (int c = 0; c < 2; c++) begin
      in_steady = ($urandom_range(0, 2) == 0);
      while (fifo_cnt[c] < QDEPTH) send_item(MODE_LOAD, rand_tick(), TICK_MAX, 1'(c));
      repeat (3) send_item(MODE_LOAD, rand_tick(), rand_tick(), 1'(c));
    end
    in_steady = 1'b0;
    while (fifo_cnt[CLASS_SYSTEM] + fifo_cnt[CLASS_USER] > 0) send_dispatch();
    send_dispatch();
  endtask

  task automatic test_random_mix();
    int load_pct;
    int class_style;
    logic cls;
    for (int chunk = 0; chunk < 3; chunk++) begin
      case ($urandom_range(0, 3))
        0: load_pct = 20;
        1: load_pct = 50;
        2: load_pct = 80;
        default: load_pct = 100;
      endcase
      class_style = $urandom_range(0, 2);
      in_steady = ($urandom_range(0, 3) == 0);
      repeat (50) begin
        cls = (class_style == 2) ? 1'($urandom_range(0, 1)) : 1'(class_style);
        if ($urandom_range(0, 99) < load_pct) send_item(MODE_LOAD, rand_tick(), rand_tick(), cls);
        else send_dispatch();
      end
    end
    in_steady = 1'b0;
  endtask

  // max bursts until the clock saturates and the turnaround total wraps
  task automatic test_clock_saturation();
    int pairs;
    int tail;
    pairs = 0;
    tail = 0;
    tat_carry = 1'b0;
    while (tail < 8 && pairs < 700) begin
      if (pairs % 40 == 0) in_steady = ($urandom_range(0, 2) == 0);
      send_item(MODE_LOAD, 16'($urandom_range(0, 65535)), TICK_MAX, 1'($urandom_range(0, 1)));
      send_dispatch();
      pairs++;
      if (sched_clock == CLOCK_MAX && tat_carry) tail++;
    end
    in_steady = 1'b0;
  endtask

  // result side back-pressure: ready stretches and random stalls
  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end else begin
        stall = idle_cycles();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with status %0d and none expected", out_status));
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(out_status), 32'(want.status));
        check_field("job_number", 32'(out_job_number), 32'(want.number));
        check_field("from_user_queue", 32'(out_from_user_queue), 32'(want.from_user));
        check_field("completion_time", 32'(out_completion_time), 32'(want.completion));
        check_field("turnaround", {7'd0, out_turnaround}, {7'd0, want.turnaround});
        check_field("waiting", {7'd0, out_waiting}, {7'd0, want.waiting});
        check_field("turnaround_total", {out_turnaround_total}, want.turnaround_total);
        check_field("waiting_total", {out_waiting_total}, want.waiting_total);
      end
    end
  end

  initial begin
    int waited;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_queue_full();
    test_random_mix();
    test_clock_saturation();
    in_valid <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
